>>> hw/rtl/xcp_pkg.sv
// shared types and codes of the xsvf command parser
package xcp_pkg;

    localparam int POS_W = 8;

    // command bytes
    localparam logic [7:0] CMD_COMPLETE = 8'h00;
    localparam logic [7:0] CMD_TDOMASK  = 8'h01;
    localparam logic [7:0] CMD_SIR      = 8'h02;
    localparam logic [7:0] CMD_RUNTEST  = 8'h04;
    localparam logic [7:0] CMD_REPEAT   = 8'h07;
    localparam logic [7:0] CMD_SDRSIZE  = 8'h08;
    localparam logic [7:0] CMD_SDRTDO   = 8'h09;
    localparam logic [7:0] CMD_STATE    = 8'h12;

    // event codes
    localparam logic [3:0] EV_SIR      = 4'd0;
    localparam logic [3:0] EV_REPEAT   = 4'd1;
    localparam logic [3:0] EV_STATE    = 4'd2;
    localparam logic [3:0] EV_RUNTEST  = 4'd3;
    localparam logic [3:0] EV_SDRSIZE  = 4'd4;
    localparam logic [3:0] EV_MASK     = 4'd5;
    localparam logic [3:0] EV_TDI      = 4'd6;
    localparam logic [3:0] EV_TDO      = 4'd7;
    localparam logic [3:0] EV_COMPLETE = 4'd8;
    localparam logic [3:0] EV_ERROR    = 4'd9;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_SIZE  = 3'd1;
    localparam logic [2:0] ERR_ILLEGAL  = 3'd2;
    localparam logic [2:0] ERR_SIR_ZERO = 3'd3;
    localparam logic [2:0] ERR_BAD_SIZE = 3'd4;

    localparam logic [2:0] COUNT_WORD = 3'd4;

    typedef enum logic [10:0] {
        PH_IDLE     = 11'b000_0000_0001,
        PH_SIR_LEN  = 11'b000_0000_0010,
        PH_SIR_DATA = 11'b000_0000_0100,
        PH_REPEAT   = 11'b000_0000_1000,
        PH_STATE    = 11'b000_0001_0000,
        PH_RUNTEST  = 11'b000_0010_0000,
        PH_SDRSIZE  = 11'b000_0100_0000,
        PH_MASK     = 11'b000_1000_0000,
        PH_TDI      = 11'b001_0000_0000,
        PH_TDO      = 11'b010_0000_0000,
        PH_HALT     = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [31:0] value;
        logic [6:0]  byte_index;
        logic [7:0]  mask_byte;
        logic [10:0] bit_count;
        logic        last_of_run;
        logic [2:0]  error_code;
    } t_result;

    function automatic t_result error_result(input logic [2:0] code);
        t_result r;
        r = '0;
        r.event_res  = EV_ERROR;
        r.error_code = code;
        return r;
    endfunction

endpackage

>>> hw/rtl/xcp_ram.sv
// generic simple dual-port ram with registered read
module xcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/xcp_decode.sv
// command decoder: parser state and per-byte result logic
module xcp_decode
    import xcp_pkg::*;
#(
    parameter int MAX_VECTOR_BYTES = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_has_result,
    output t_result                             o_result,
    output logic                                o_ram_we,
    output logic [$clog2(MAX_VECTOR_BYTES)-1:0] o_ram_waddr,
    output logic [7:0]                          o_ram_wdata,
    output logic [$clog2(MAX_VECTOR_BYTES)-1:0] o_ram_raddr,
    input  logic [7:0]                          i_ram_rdata
);

    localparam int AW    = $clog2(MAX_VECTOR_BYTES);
    localparam int SDR_W = $clog2(8 * MAX_VECTOR_BYTES + 1);

    t_phase             r_phase, n_phase;
    logic [2:0]         r_count, n_count;
    logic [7:0]         r_sir_len, n_sir_len;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [SDR_W-1:0]   r_sdr, n_sdr;
    logic [31:0]        r_acc, n_acc;
    logic [2:0]         r_halt, n_halt;
    logic [MAX_VECTOR_BYTES-1:0] r_mvalid;

    logic [15:0] w_pos_ext, w_pos_inc, w_sdr_ext, w_nbytes, w_sir_nbytes, w_rd_ext;
    logic [15:0] w_acc_sh;
    logic [16:0] w_acc_bytes;
    logic [2:0]  w_count_dec;
    logic        w_in_range, w_vec_last, w_sir_last, w_size_bad;
    logic [AW-1:0] w_pos_addr;
    logic [7:0]  w_mask_rd;
    logic [POS_W-1:0] w_rd_pos;

    assign w_pos_ext    = {8'b0, r_pos};
    assign w_pos_inc    = w_pos_ext + 16'd1;
    assign w_sdr_ext    = 16'(r_sdr);
    assign w_nbytes     = (w_sdr_ext + 16'd7) >> 3;
    assign w_sir_nbytes = ({8'b0, r_sir_len} + 16'd7) >> 3;
    assign w_in_range   = w_pos_ext < 16'(MAX_VECTOR_BYTES);
    assign w_vec_last   = w_pos_inc >= w_nbytes;
    assign w_sir_last   = w_pos_inc == w_sir_nbytes;
    assign w_pos_addr   = w_pos_ext[AW-1:0];
    assign w_acc_sh     = {r_acc[7:0], i_data_byte};
    assign w_acc_bytes  = ({1'b0, w_acc_sh} + 17'd7) >> 3;
    assign w_size_bad   = w_acc_bytes > 17'(MAX_VECTOR_BYTES);
    assign w_count_dec  = r_count - 3'd1;

    // never-written entries read as zero
    assign w_mask_rd = (w_in_range && r_mvalid[w_pos_addr]) ? i_ram_rdata : 8'h00;

    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_sir_len    = r_sir_len;
        n_pos        = r_pos;
        n_sdr        = r_sdr;
        n_acc        = r_acc;
        n_halt       = r_halt;
        o_has_result = 1'b0;
        o_result     = '0;

        unique case (r_phase)
            PH_IDLE: begin
                n_pos   = '0;
                n_count = '0;
                unique case (i_data_byte) inside
                    CMD_COMPLETE: begin
                        n_phase               = PH_HALT;
                        n_halt                = ERR_ILLEGAL;
                        o_has_result          = 1'b1;
                        o_result.event_res    = EV_COMPLETE;
                        o_result.last_of_run  = 1'b1;
                    end
                    CMD_TDOMASK, CMD_SDRTDO: begin
                        if (r_sdr == '0) begin
                            n_phase      = PH_HALT;
                            n_halt       = ERR_NO_SIZE;
                            o_has_result = 1'b1;
                            o_result     = error_result(ERR_NO_SIZE);
                        end else begin
                            n_phase = (i_data_byte == CMD_TDOMASK) ? PH_MASK : PH_TDI;
                        end
                    end
                    CMD_SIR: n_phase = PH_SIR_LEN;
                    CMD_RUNTEST: begin
                        n_acc   = '0;
                        n_count = COUNT_WORD;
                        n_phase = PH_RUNTEST;
                    end
                    CMD_REPEAT: n_phase = PH_REPEAT;
                    CMD_SDRSIZE: begin
                        n_sdr   = '0;
                        n_acc   = '0;
                        n_count = COUNT_WORD;
                        n_phase = PH_SDRSIZE;
                    end
                    CMD_STATE: n_phase = PH_STATE;
                    default: begin
                        n_phase      = PH_HALT;
                        n_halt       = ERR_ILLEGAL;
                        o_has_result = 1'b1;
                        o_result     = error_result(ERR_ILLEGAL);
                    end
                endcase
            end
            PH_SIR_LEN: begin
                if (i_data_byte == 8'h00) begin
                    n_phase      = PH_HALT;
                    n_halt       = ERR_SIR_ZERO;
                    o_has_result = 1'b1;
                    o_result     = error_result(ERR_SIR_ZERO);
                end else begin
                    n_sir_len = i_data_byte;
                    n_pos     = '0;
                    n_phase   = PH_SIR_DATA;
                end
            end
            PH_SIR_DATA: begin
                n_pos = w_pos_inc[POS_W-1:0];
                if (w_sir_last) begin
                    n_phase = PH_IDLE;
                end
                o_has_result         = 1'b1;
                o_result.event_res   = EV_SIR;
                o_result.value       = {24'b0, i_data_byte};
                o_result.byte_index  = r_pos[6:0];
                o_result.bit_count   = {3'b0, r_sir_len};
                o_result.last_of_run = w_sir_last;
            end
            PH_REPEAT, PH_STATE: begin
                n_phase              = PH_IDLE;
                o_has_result         = 1'b1;
                o_result.event_res   = (r_phase == PH_REPEAT) ? EV_REPEAT : EV_STATE;
                o_result.value       = {24'b0, i_data_byte};
                o_result.last_of_run = 1'b1;
            end
            PH_RUNTEST: begin
                n_acc   = {r_acc[23:0], i_data_byte};
                n_count = w_count_dec;
                if (w_count_dec == 3'd0) begin
                    n_phase              = PH_IDLE;
                    o_has_result         = 1'b1;
                    o_result.event_res   = EV_RUNTEST;
                    o_result.value       = {r_acc[23:0], i_data_byte};
                    o_result.last_of_run = 1'b1;
                end
            end
            PH_SDRSIZE: begin
                n_count = w_count_dec;
                if (w_count_dec > 3'd1) begin
                    // upper half of the size word must be zero
                    if (i_data_byte != 8'h00) begin
                        n_phase      = PH_HALT;
                        n_halt       = ERR_BAD_SIZE;
                        o_has_result = 1'b1;
                        o_result     = error_result(ERR_BAD_SIZE);
                    end
                end else begin
                    n_acc = {16'b0, w_acc_sh};
                    if (w_count_dec == 3'd0) begin
                        if (w_size_bad) begin
                            n_phase      = PH_HALT;
                            n_halt       = ERR_BAD_SIZE;
                            o_has_result = 1'b1;
                            o_result     = error_result(ERR_BAD_SIZE);
                        end else begin
                            n_sdr                = w_acc_sh[SDR_W-1:0];
                            n_phase              = PH_IDLE;
                            o_has_result         = 1'b1;
                            o_result.event_res   = EV_SDRSIZE;
                            o_result.value       = {16'b0, w_acc_sh};
                            o_result.bit_count   = w_acc_sh[10:0];
                            o_result.last_of_run = 1'b1;
                        end
                    end
                end
            end
            PH_MASK, PH_TDI, PH_TDO: begin
                o_has_result         = 1'b1;
                o_result.value       = {24'b0, i_data_byte};
                o_result.byte_index  = r_pos[6:0];
                o_result.bit_count   = w_sdr_ext[10:0];
                o_result.last_of_run = w_vec_last;
                if (r_phase == PH_MASK) begin
                    o_result.event_res = EV_MASK;
                end else if (r_phase == PH_TDI) begin
                    o_result.event_res = EV_TDI;
                end else begin
                    o_result.event_res = EV_TDO;
                    o_result.mask_byte = w_mask_rd;
                end
                n_pos = w_pos_inc[POS_W-1:0];
                if (w_vec_last) begin
                    n_pos   = '0;
                    n_phase = (r_phase == PH_TDI) ? PH_TDO : PH_IDLE;
                end
            end
            PH_HALT: begin
                n_phase      = PH_HALT;
                n_halt       = (r_halt == ERR_NONE) ? ERR_ILLEGAL : r_halt;
                o_has_result = 1'b1;
                o_result     = error_result(n_halt);
            end
            default: begin
                n_phase      = PH_HALT;
                n_halt       = ERR_ILLEGAL;
                o_has_result = 1'b1;
                o_result     = error_result(ERR_ILLEGAL);
            end
        endcase
    end

    // mask write at the current position, read one byte ahead so the
    // registered data is ready when the next transaction arrives
    assign o_ram_we    = i_accept && (r_phase == PH_MASK) && w_in_range;
    assign o_ram_waddr = w_pos_addr;
    assign o_ram_wdata = i_data_byte;
    assign w_rd_pos    = i_accept ? n_pos : r_pos;
    assign w_rd_ext    = {8'b0, w_rd_pos};
    assign o_ram_raddr = w_rd_ext[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_count   <= '0;
            r_sir_len <= '0;
            r_pos     <= '0;
            r_sdr     <= '0;
            r_acc     <= '0;
            r_halt    <= ERR_NONE;
            r_mvalid  <= '0;
        end else begin
            if (i_accept) begin
                r_phase   <= n_phase;
                r_count   <= n_count;
                r_sir_len <= n_sir_len;
                r_pos     <= n_pos;
                r_sdr     <= n_sdr;
                r_acc     <= n_acc;
                r_halt    <= n_halt;
            end
            if (o_ram_we) begin
                r_mvalid[w_pos_addr] <= 1'b1;
            end
        end
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALT |=> r_phase == PH_HALT)
        else $error("parser left halt without reset");

    a_error_coded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_has_result && o_result.event_res == EV_ERROR |-> o_result.error_code != ERR_NONE)
        else $error("error event without an error code");

    a_halt_code_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALT |-> r_halt != ERR_NONE)
        else $error("halted with no halt code");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_WORD)
        else $error("operand byte counter out of range");

endmodule

>>> hw/rtl/xsvf_command_parser_core.sv
// top level of the xsvf command parser: decoder, mask ram, output skid
//
//  channel  dir  handshake           payload
//  input    in   i_valid / o_stall   i_data_byte
//  result   out  o_valid / i_stall   o_event_res, o_value, o_byte_index, o_mask_byte,
//                                    o_bit_count, o_last_of_run, o_error_code
//
// one byte per cycle while o_stall is low; each byte is decoded in one pass from the parser state
// into the result register, and the registered mask read is addressed a byte ahead.
// a result is registered in the result register, or in the skid while the output stalls;
// silent bytes give none. synchronous active-low reset; the mask store is cleared by per-entry
// valid bits. a one-entry skid behind the result register absorbs a stall; o_stall rises
// only while the skid holds a result.
module xsvf_command_parser_core
    import xcp_pkg::*;
#(
    parameter int MAX_VECTOR_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_event_res,
    output logic [31:0] o_value,
    output logic [6:0]  o_byte_index,
    output logic [7:0]  o_mask_byte,
    output logic [10:0] o_bit_count,
    output logic        o_last_of_run,
    output logic [2:0]  o_error_code
);

    localparam int AW = $clog2(MAX_VECTOR_BYTES);

    logic          w_accept, w_has_result, w_out_fire;
    t_result       w_result;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr, w_ram_raddr;
    logic [7:0]    w_ram_wdata, w_ram_rdata;

    t_result r_out, n_out, r_skid, n_skid;
    logic    r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;

    assign o_stall    = r_skid_valid;
    assign w_accept   = i_valid && !r_skid_valid;
    assign w_out_fire = r_out_valid && !i_stall;

    xcp_decode #(
        .MAX_VECTOR_BYTES(MAX_VECTOR_BYTES)
    ) u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_data_byte  (i_data_byte),
        .o_has_result (w_has_result),
        .o_result     (w_result),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (w_ram_rdata)
    );

    xcp_ram #(
        .WIDTH(8),
        .DEPTH(MAX_VECTOR_BYTES)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (w_out_fire) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (w_accept && w_has_result) begin
            if (!r_out_valid || w_out_fire) begin
                n_out       = w_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = w_result;
                n_skid_valid = 1'b1;
            end
        end else if (w_out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid       = r_out_valid;
    assign o_event_res   = r_out.event_res;
    assign o_value       = r_out.value;
    assign o_byte_index  = r_out.byte_index;
    assign o_mask_byte   = r_out.mask_byte;
    assign o_bit_count   = r_out.bit_count;
    assign o_last_of_run = r_out.last_of_run;
    assign o_error_code  = r_out.error_code;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid filled without a stalled output");

    a_result_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_has_result && (!r_out_valid || !i_stall)
        |=> r_out_valid && !r_skid_valid)
        else $error("result did not go straight to the output register");

endmodule

>>> dv/xsvf_command_parser_core_tb.sv
// self-checking testbench for the xsvf command parser core
`timescale 1ns / 1ps

module xsvf_command_parser_core_tb
    import xcp_pkg::*;
();

    localparam int MAX_VEC     = 128;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_BYTES = 1200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_event_res;
    logic [31:0] o_value;
    logic [6:0]  o_byte_index;
    logic [7:0]  o_mask_byte;
    logic [10:0] o_bit_count;
    logic        o_last_of_run;
    logic [2:0]  o_error_code;

    xsvf_command_parser_core #(
        .MAX_VECTOR_BYTES(MAX_VEC)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_res  (o_event_res),
        .o_value      (o_value),
        .o_byte_index (o_byte_index),
        .o_mask_byte  (o_mask_byte),
        .o_bit_count  (o_bit_count),
        .o_last_of_run(o_last_of_run),
        .o_error_code (o_error_code)
    );

    // parser state as the stream has been consumed so far
    t_phase      cur_phase = PH_IDLE;
    logic [2:0]  bytes_left = '0;
    logic [7:0]  sir_len = '0;
    logic [7:0]  vec_pos = '0;
    logic [10:0] sdr_bits = '0;
    logic [31:0] word_acc = '0;
    logic [7:0]  mask_copy [MAX_VEC];
    logic [2:0]  halt_err = '0;

    logic [7:0]  stream_bytes [$];
    t_result     due_events [$];
    int          queued_bytes = 0;
    int          gen_sdr_bits = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          cycles = 0;
    logic        in_fire = 1'b0;
    int          tx_gap = 0;
    bit          tx_calm = 1'b0;
    int          stall_left = 0;
    bit          rx_calm = 1'b0;
    bit          long_hold_done = 1'b0;

    function automatic int byte_len(input int unsigned bits);
        return (bits + 7) >> 3;
    endfunction

    function automatic bit halt_with(input logic [2:0] code, output t_result r);
        cur_phase = PH_HALT;
        halt_err = code;
        r = '0;
        r.event_res = EV_ERROR;
        r.error_code = code;
        return 1'b1;
    endfunction

    // returns 1 when the byte produces an event, which is placed in r
    function automatic bit decode_xsvf_byte(input logic [7:0] b, output t_result r);
        logic [7:0] pos;
        logic       is_last;
        r = '0;
        case (cur_phase)
            PH_IDLE: begin
                vec_pos = '0;
                bytes_left = '0;
                case (b)
                    CMD_COMPLETE: begin
                        cur_phase = PH_HALT;
                        halt_err = ERR_ILLEGAL;
                        r.event_res = EV_COMPLETE;
                        r.last_of_run = 1'b1;
                        return 1'b1;
                    end
                    CMD_TDOMASK, CMD_SDRTDO: begin
                        if (sdr_bits == 0) return halt_with(ERR_NO_SIZE, r);
                        cur_phase = (b == CMD_TDOMASK) ? PH_MASK : PH_TDI;
                        return 1'b0;
                    end
                    CMD_SIR: begin
                        cur_phase = PH_SIR_LEN;
                        return 1'b0;
                    end
                    CMD_RUNTEST: begin
                        word_acc = '0;
                        bytes_left = COUNT_WORD;
                        cur_phase = PH_RUNTEST;
                        return 1'b0;
                    end
                    CMD_REPEAT: begin
                        cur_phase = PH_REPEAT;
                        return 1'b0;
                    end
                    CMD_SDRSIZE: begin
                        sdr_bits = '0;
                        word_acc = '0;
                        bytes_left = COUNT_WORD;
                        cur_phase = PH_SDRSIZE;
                        return 1'b0;
                    end
                    CMD_STATE: begin
                        cur_phase = PH_STATE;
                        return 1'b0;
                    end
                    default: return halt_with(ERR_ILLEGAL, r);
                endcase
            end
            PH_SIR_LEN: begin
                if (b == 8'h00) return halt_with(ERR_SIR_ZERO, r);
                sir_len = b;
                vec_pos = '0;
                cur_phase = PH_SIR_DATA;
                return 1'b0;
            end
            PH_SIR_DATA: begin
                pos = vec_pos;
                is_last = (int'(pos) + 1 == byte_len(sir_len));
                vec_pos = pos + 8'd1;
                if (is_last) cur_phase = PH_IDLE;
                r.event_res = EV_SIR;
                r.value = {24'h0, b};
                r.byte_index = pos[6:0];
                r.bit_count = {3'b000, sir_len};
                r.last_of_run = is_last;
                return 1'b1;
            end
            PH_REPEAT, PH_STATE: begin
                r.event_res = (cur_phase == PH_REPEAT) ? EV_REPEAT : EV_STATE;
                r.value = {24'h0, b};
                r.last_of_run = 1'b1;
                cur_phase = PH_IDLE;
                return 1'b1;
            end
            PH_RUNTEST: begin
                word_acc = {word_acc[23:0], b};
                bytes_left = bytes_left - 3'd1;
                if (bytes_left != 0) return 1'b0;
                cur_phase = PH_IDLE;
                r.event_res = EV_RUNTEST;
                r.value = word_acc;
                r.last_of_run = 1'b1;
                return 1'b1;
            end
            PH_SDRSIZE: begin
                bytes_left = bytes_left - 3'd1;
                // the upper half of the size word must be zero
                if (bytes_left > 3'd1) begin
                    if (b != 8'h00) return halt_with(ERR_BAD_SIZE, r);
                    return 1'b0;
                end
                word_acc = {16'h0, word_acc[7:0], b};
                if (bytes_left != 0) return 1'b0;
                if (byte_len(word_acc) > MAX_VEC) return halt_with(ERR_BAD_SIZE, r);
                sdr_bits = word_acc[10:0];
                cur_phase = PH_IDLE;
                r.event_res = EV_SDRSIZE;
                r.value = {21'h0, sdr_bits};
                r.bit_count = sdr_bits;
                r.last_of_run = 1'b1;
                return 1'b1;
            end
            PH_MASK, PH_TDI, PH_TDO: begin
                pos = vec_pos;
                is_last = (int'(pos) + 1 >= byte_len(sdr_bits));
                r.value = {24'h0, b};
                r.byte_index = pos[6:0];
                r.bit_count = sdr_bits;
                r.last_of_run = is_last;
                if (cur_phase == PH_MASK) begin
                    r.event_res = EV_MASK;
                    if (pos < MAX_VEC) mask_copy[pos[6:0]] = b;
                end else if (cur_phase == PH_TDI) begin
                    r.event_res = EV_TDI;
                end else begin
                    r.event_res = EV_TDO;
                    r.mask_byte = (pos < MAX_VEC) ? mask_copy[pos[6:0]] : 8'h00;
                end
                vec_pos = pos + 8'd1;
                if (is_last) begin
                    vec_pos = '0;
                    cur_phase = (cur_phase == PH_TDI) ? PH_TDO : PH_IDLE;
                end
                return 1'b1;
            end
            default: begin
                cur_phase = PH_HALT;
                if (halt_err == ERR_NONE) halt_err = ERR_ILLEGAL;
                r = '0;
                r.event_res = EV_ERROR;
                r.error_code = halt_err;
                return 1'b1;
            end
        endcase
    endfunction

    // mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_byte(input logic [7:0] b);
        stream_bytes.push_back(b);
        queued_bytes++;
    endtask

    task automatic add_sdrsize(input int bits);
        push_byte(CMD_SDRSIZE);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(bits[15:8]);
        push_byte(bits[7:0]);
        gen_sdr_bits = bits;
    endtask

    task automatic add_sir(input int len);
        push_byte(CMD_SIR);
        push_byte(len[7:0]);
        repeat (byte_len(len)) push_byte(8'($urandom_range(0, 255)));
    endtask

    // a mask loads one vector, a scan carries tdi then tdo
    task automatic add_scan(input logic [7:0] cmd);
        push_byte(cmd);
        repeat (byte_len(gen_sdr_bits) * ((cmd == CMD_SDRTDO) ? 2 : 1))
            push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic add_runtest(input logic [31:0] count);
        push_byte(CMD_RUNTEST);
        push_byte(count[31:24]);
        push_byte(count[23:16]);
        push_byte(count[15:8]);
        push_byte(count[7:0]);
    endtask

    function automatic int pick_sdr_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 32);
        if (r < 85) return $urandom_range(33, 255);
        if (r < 92) return $urandom_range(256, 1023);
        if (r < 97) return 8 * MAX_VEC;
        return 0;
    endfunction

    function automatic bit is_command(input logic [7:0] b);
        return b == CMD_COMPLETE || b == CMD_TDOMASK || b == CMD_SIR || b == CMD_RUNTEST ||
               b == CMD_REPEAT || b == CMD_SDRSIZE || b == CMD_SDRTDO || b == CMD_STATE;
    endfunction

    task automatic wait_drained();
        while (stream_bytes.size() != 0 || i_valid || due_events.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("xsvf_command_parser_core verification failed");
            $finish;
        end
    end

    // driver: one byte per transaction, random gaps between them
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (in_fire || !i_valid) begin
            if (tx_gap != 0) begin
                i_valid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end else if (stream_bytes.size() != 0) begin
                i_valid <= 1'b1;
                i_data_byte <= stream_bytes.pop_front();
                tx_gap <= tx_calm ? 0 : gap_len();
            end else begin
                i_valid <= 1'b0;
            end
        end
        if ($urandom_range(0, 249) == 0) tx_calm <= !tx_calm;
    end

    // receiver back-pressure, with one long hold-off once traffic is flowing
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!long_hold_done && results_seen >= 150) begin
            i_stall <= 1'b1;
            stall_left <= 400;
            long_hold_done <= 1'b1;
        end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
            stall_left <= gap_len();
        end else begin
            i_stall <= 1'b0;
        end
        if ($urandom_range(0, 299) == 0) rx_calm <= !rx_calm;
    end

    // monitor: check delivered results first, then predict from the accepted byte
    always @(posedge i_clk) begin
        t_result want;
        t_result pred;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (due_events.size() == 0) begin
                    mismatches++;
                    $display("%0t: event_res expected none actual %0h value %0h",
                             $time, o_event_res, o_value);
                end else begin
                    want = due_events.pop_front();
                    check_field("event_res", 32'(want.event_res), 32'(o_event_res));
                    check_field("value", want.value, o_value);
                    check_field("byte_index", 32'(want.byte_index), 32'(o_byte_index));
                    check_field("mask_byte", 32'(want.mask_byte), 32'(o_mask_byte));
                    check_field("bit_count", 32'(want.bit_count), 32'(o_bit_count));
                    check_field("last_of_run", 32'(want.last_of_run), 32'(o_last_of_run));
                    check_field("error_code", 32'(want.error_code), 32'(o_error_code));
                end
            end
            in_fire <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                if (decode_xsvf_byte(i_data_byte, pred)) due_events.push_back(pred);
            end
        end
    end

    initial begin
        int pick;
        int target;
        logic [7:0] b;
        for (int k = 0; k < MAX_VEC; k++) mask_copy[k] = 8'h00;

        // directed: tdo before any mask load, extreme runtest, repeat and state operands
        add_sdrsize(8);
        push_byte(CMD_SDRTDO);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(CMD_TDOMASK);
        push_byte(8'hA5);
        push_byte(CMD_SDRTDO);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CMD_SIR);
        push_byte(8'd9);
        push_byte(8'hFF);
        push_byte(8'h00);
        add_runtest(32'hFFFF_FFFF);
        push_byte(CMD_REPEAT);
        push_byte(8'hFF);
        push_byte(CMD_STATE);
        push_byte(8'h00);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender holds back until the directed part has fully come out
        wait_drained();

        target = queued_bytes + RANDOM_BYTES;
        while (queued_bytes < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 18) begin
                add_sdrsize(pick_sdr_size());
            end else if (pick < 33) begin
                if (gen_sdr_bits != 0) add_scan(CMD_TDOMASK);
            end else if (pick < 58) begin
                if (gen_sdr_bits != 0) add_scan(CMD_SDRTDO);
            end else if (pick < 73) begin
                add_sir(($urandom_range(0, 9) == 0) ? $urandom_range(25, 255)
                                                   : $urandom_range(1, 24));
            end else if (pick < 85) begin
                add_runtest(($urandom_range(0, 7) == 0) ? 32'h0 : $urandom());
            end else if (pick < 93) begin
                push_byte(CMD_REPEAT);
                push_byte(8'($urandom_range(0, 255)));
            end else begin
                push_byte(CMD_STATE);
                push_byte(8'($urandom_range(0, 255)));
            end
        end

        // the halt is sticky, so one way of ending the stream per run
        case ($urandom_range(0, 5))
            0: push_byte(CMD_COMPLETE);
            1: begin
                do b = 8'($urandom_range(0, 255)); while (is_command(b));
                push_byte(b);
            end
            2: begin
                push_byte(CMD_SIR);
                push_byte(8'h00);
            end
            3: begin
                add_sdrsize(0);
                push_byte(($urandom_range(0, 1) == 0) ? CMD_TDOMASK : CMD_SDRTDO);
            end
            4: begin
                push_byte(CMD_SDRSIZE);
                if ($urandom_range(0, 1) == 0) push_byte(8'($urandom_range(1, 255)));
                else begin
                    push_byte(8'h00);
                    push_byte(8'($urandom_range(1, 255)));
                end
            end
            default: add_sdrsize($urandom_range(8 * MAX_VEC + 1, 65535));
        endcase
        repeat ($urandom_range(5, 20)) push_byte(8'($urandom_range(0, 255)));

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("xsvf_command_parser_core verification clean");
        end else begin
            $display("xsvf_command_parser_core verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/xcp_pkg.sv
hw/rtl/xcp_ram.sv
hw/rtl/xcp_decode.sv
hw/rtl/xsvf_command_parser_core.sv
dv/xsvf_command_parser_core_tb.sv
